>>> rtl/core/bsle_pkg.sv
package bsle_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6,
        OP_SET_AT     = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_RANGE   = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UP_TEST,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DN_TEST,
        S_DN_RD,
        S_DN_WR,
        S_FIND_TEST,
        S_FIND_RD,
        S_FIND_CMP,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_CNT,
        CUR_POS1,
        CUR_ZERO,
        CUR_INC,
        CUR_DEC
    } cur_mode_t;

    typedef enum logic {
        RD_BELOW,
        RD_AT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT_UP,
        WR_SHIFT_DN,
        WR_POS
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_mode_t;

    typedef struct packed {
        logic      load;
        cur_mode_t cur_mode;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        cnt_mode_t cnt_mode;
        logic      st_we;
        status_t   st_code;
        logic      found_we;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    pos_gt_cnt;
        logic    pos_ge_cnt;
        logic    full;
        logic    empty;
        logic    cur_lt_cnt;
        logic    cur_gt_pos;
        logic    match;
    } dp_stat_t;

endpackage

>>> rtl/core/bsle_ctrl.sv
module bsle_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bsle_pkg::dp_stat_t stat,
    output bsle_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import bsle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (stat.op)
                    OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
                    begin
                        if (stat.pos_gt_cnt || stat.full)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_UP_TEST;
                        end
                    end
                    OP_POP_BACK:
                    begin
                        state_next = S_DONE;
                    end
                    OP_POP_FRONT:
                    begin
                        state_next = stat.empty ? S_DONE : S_DN_TEST;
                    end
                    OP_ERASE:
                    begin
                        state_next = stat.pos_ge_cnt ? S_DONE : S_DN_TEST;
                    end
                    OP_FIND:
                    begin
                        state_next = S_FIND_TEST;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_UP_TEST:   state_next = stat.cur_gt_pos ? S_UP_RD : S_PUT;
            S_UP_RD:     state_next = S_UP_WR;
            S_UP_WR:     state_next = S_UP_TEST;
            S_PUT:       state_next = S_DONE;
            S_DN_TEST:   state_next = stat.cur_lt_cnt ? S_DN_RD : S_DONE;
            S_DN_RD:     state_next = S_DN_WR;
            S_DN_WR:     state_next = S_DN_TEST;
            S_FIND_TEST: state_next = stat.cur_lt_cnt ? S_FIND_RD : S_DONE;
            S_FIND_RD:   state_next = S_FIND_CMP;
            S_FIND_CMP:  state_next = stat.match ? S_DONE : S_FIND_TEST;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load     = 1'b0;
        cmd.cur_mode = CUR_HOLD;
        cmd.rd_en    = 1'b0;
        cmd.rd_sel   = RD_AT;
        cmd.wr_en    = 1'b0;
        cmd.wr_sel   = WR_POS;
        cmd.cnt_mode = CNT_HOLD;
        cmd.st_we    = 1'b0;
        cmd.st_code  = ST_OK;
        cmd.found_we = 1'b0;
        busy         = 1'b1;
        done         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_CHECK:
            begin
                cmd.st_we = 1'b1;
                case (stat.op)
                    OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
                    begin
                        // range is tested before full
                        if (stat.pos_gt_cnt)
                        begin
                            cmd.st_code = ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            cmd.st_code = ST_FULL;
                        end
                        cmd.cur_mode = CUR_CNT;
                    end
                    OP_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.cnt_mode = CNT_DEC;
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_code = ST_EMPTY;
                        end
                        cmd.cur_mode = CUR_POS1;
                    end
                    OP_ERASE:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.st_code = ST_RANGE;
                        end
                        cmd.cur_mode = CUR_POS1;
                    end
                    OP_FIND:
                    begin
                        cmd.st_code  = ST_MISSING;
                        cmd.cur_mode = CUR_ZERO;
                    end
                    default:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.st_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_POS;
                        end
                    end
                endcase
            end
            S_UP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_BELOW;
            end
            S_UP_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_SHIFT_UP;
                cmd.cur_mode = CUR_DEC;
            end
            S_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_POS;
                cmd.cnt_mode = CNT_INC;
            end
            S_DN_TEST:
            begin
                if (!stat.cur_lt_cnt)
                begin
                    cmd.cnt_mode = CNT_DEC;
                end
            end
            S_DN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT;
            end
            S_DN_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_SHIFT_DN;
                cmd.cur_mode = CUR_INC;
            end
            S_FIND_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT;
            end
            S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.st_we    = 1'b1;
                    cmd.st_code  = ST_OK;
                    cmd.found_we = 1'b1;
                end
                else
                begin
                    cmd.cur_mode = CUR_INC;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/bsle_datapath.sv
module bsle_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsle_pkg::dp_cmd_t  cmd,
    output bsle_pkg::dp_stat_t stat,
    input  logic [2:0]        opcode,
    input  logic [4:0]        position,
    input  logic signed [31:0] value,
    output logic [2:0]        status,
    output logic [3:0]        found_index,
    output logic [4:0]        count
);
    import bsle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    opcode_t               op_reg;
    logic [PW-1:0]         pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         cursor_reg;
    logic [CW-1:0]         cursor_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    status_t               status_reg;
    logic [AW-1:0]         found_reg;
    logic [PW-1:0]         pos_load;
    logic [CW-1:0]         cursor_below;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    assign cursor_below = cursor_reg - CW'(1);

    // front operations run as insert or erase at index zero, push back as insert at count
    always_comb
    begin
        case (opcode_t'(opcode))
            OP_PUSH_BACK:               pos_load = PW'(count_reg);
            OP_PUSH_FRONT, OP_POP_FRONT: pos_load = '0;
            default:                    pos_load = PW'(position);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(opcode);
            pos_reg <= pos_load;
            val_reg <= DATA_WIDTH'($unsigned(value));
        end
    end

    always_comb
    begin
        case (cmd.cur_mode)
            CUR_CNT:  cursor_next = count_reg;
            CUR_POS1: cursor_next = CW'(pos_reg) + CW'(1);
            CUR_ZERO: cursor_next = '0;
            CUR_INC:  cursor_next = cursor_reg + CW'(1);
            CUR_DEC:  cursor_next = cursor_below;
            default:  cursor_next = cursor_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
    end

    always_comb
    begin
        case (cmd.cnt_mode)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            found_reg <= '0;
        end
        else if (cmd.found_we)
        begin
            found_reg <= AW'(cursor_reg);
        end
        if (cmd.st_we)
        begin
            status_reg <= cmd.st_code;
        end
    end

    assign rd_addr = (cmd.rd_sel == RD_BELOW) ? AW'(cursor_below) : AW'(cursor_reg);

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SHIFT_UP:
            begin
                wr_addr = AW'(cursor_reg);
                wr_data = rd_data_reg;
            end
            WR_SHIFT_DN:
            begin
                wr_addr = AW'(cursor_below);
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = AW'(pos_reg);
                wr_data = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.op         = op_reg;
    assign stat.pos_gt_cnt = pos_reg > PW'(count_reg);
    assign stat.pos_ge_cnt = pos_reg >= PW'(count_reg);
    assign stat.full       = count_reg == CW'(DEPTH);
    assign stat.empty      = count_reg == '0;
    assign stat.cur_lt_cnt = cursor_reg < count_reg;
    assign stat.cur_gt_pos = PW'(cursor_reg) > pos_reg;
    assign stat.match      = rd_data_reg == val_reg;

    assign status      = status_reg;
    assign found_index = 4'(found_reg);
    assign count       = 5'(count_reg);

endmodule

>>> rtl/core/bounded_sequential_list_engine_unit.sv
// channel   | signals                          | transaction
// ----------+----------------------------------+------------------------------------
// command   | start, busy, opcode, position,   | start high while busy low
//           | value                            |
// result    | done, status, found_index, count | done high for one cycle, no stall
//
// the list lives in a single-port-write, registered-read memory; every moved or
// scanned element passes a test, a read and a write (or compare) state. pop back,
// set_at and any refused op go from check to done; insert, push front or
// push back (n = 0) shift n elements up, then write the value; erase or pop
// front shift n elements down; find scans up from index zero to a hit or count.
// rst_n clears the element count and the controller; memory contents start
// undefined. the receiver cannot stall, results appear once with done.
module bounded_sequential_list_engine_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        opcode,
    input  logic [4:0]        position,
    input  logic signed [31:0] value,
    output logic              done,
    output logic [2:0]        status,
    output logic [3:0]        found_index,
    output logic [4:0]        count
);
    import bsle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bsle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bsle_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .status      (status),
        .found_index (found_index),
        .count       (count)
    );

endmodule

>>> rtl/core/bsle_checker.sv
module bsle_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic [3:0] found_index,
    input logic [4:0] count
);
    import bsle_pkg::*;

    // an accepted transaction always makes the engine busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result never shows while a new command could be taken
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> found_index == 4'd0)
        else $error("found index set on a failed operation");

    // between results the count only moves while an operation is in flight
    assert property (@(posedge clk) disable iff (!rst_n) !busy |=> $stable(count))
        else $error("count changed while idle");

endmodule

bind bounded_sequential_list_engine_unit bsle_checker u_bsle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .count       (count)
);
